// File: sv/satr_pkg.sv
// Shared definitions for the set-associative cache tag and replacement core.
// Holds default geometry, age width and the controller state type; no dependencies.
package satr_pkg;

  // Default cache geometry.
  localparam int DEF_NUM_WAYS   = 4;
  localparam int DEF_NUM_SETS   = 16;
  localparam int DEF_LINE_BYTES = 32;
  localparam int DEF_ADDR_BITS  = 18;

  // Width of one age entry and of the global timestamp.
  localparam int AGE_W = 32;

  // Replacement policy codes.
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_PLRU = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

// File: sv/satr_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the tag rows and the valid/age rows; no package dependencies.
module satr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/satr_repl.sv
// Replacement logic: victim selection and age update for LRU and bit pseudo-LRU.
// Depends on satr_pkg for the age width and the policy codes.
module satr_repl #(
  parameter int NUM_WAYS = satr_pkg::DEF_NUM_WAYS,
  parameter int WAY_W    = $clog2(NUM_WAYS)
) (
  input  logic                                       policy,
  input  logic [NUM_WAYS-1:0][satr_pkg::AGE_W-1:0]   ages,
  input  logic [WAY_W-1:0]                           upd_way,
  input  logic [satr_pkg::AGE_W-1:0]                 ts_inc,
  output logic [WAY_W-1:0]                           victim,
  output logic [NUM_WAYS-1:0][satr_pkg::AGE_W-1:0]   ages_new
);

  localparam int LVL = WAY_W;
  localparam int PAD = 1 << LVL;

  logic [PAD-1:0][satr_pkg::AGE_W-1:0] tree_age;
  logic [PAD-1:0][WAY_W-1:0]           tree_idx;
  logic [WAY_W-1:0]                    lru_victim;
  logic [WAY_W-1:0]                    plru_victim;
  logic [NUM_WAYS-1:0]                 use_bits;

  // LRU victim: reduction tree for the lowest age, ties going to the lower way.
  always_comb begin
    for (int k = 0; k < PAD; k++) begin
      tree_age[k] = (k < NUM_WAYS) ? ages[k] : '1;
      tree_idx[k] = WAY_W'(k);
    end
    for (int lv = 0; lv < LVL; lv++) begin
      for (int k = 0; k < (PAD >> (lv + 1)); k++) begin
        if (tree_age[2*k+1] < tree_age[2*k]) begin
          tree_age[k] = tree_age[2*k+1];
          tree_idx[k] = tree_idx[2*k+1];
        end else begin
          tree_age[k] = tree_age[2*k];
          tree_idx[k] = tree_idx[2*k];
        end
      end
    end
    lru_victim = tree_idx[0];
  end

  // Pseudo-LRU victim: first way whose use bit is clear, else way 0.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      use_bits[w] = (ages[w] != '0);
    end
    plru_victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!use_bits[w]) begin
        plru_victim = WAY_W'(w);
      end
    end
  end

  assign victim = (policy == satr_pkg::POLICY_PLRU) ? plru_victim : lru_victim;

  // Age refresh of the way that was used. Under pseudo-LRU the other ages are
  // kept as they are, unless every way would be marked; then they are cleared.
  always_comb begin
    logic [NUM_WAYS-1:0] bits;
    bits = use_bits;
    bits[upd_way] = 1'b1;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (policy == satr_pkg::POLICY_PLRU) begin
        if (WAY_W'(w) == upd_way) begin
          ages_new[w] = {{(satr_pkg::AGE_W-1){1'b0}}, 1'b1};
        end else if (&bits) begin
          ages_new[w] = '0;
        end else begin
          ages_new[w] = ages[w];
        end
      end else begin
        ages_new[w] = (WAY_W'(w) == upd_way) ? ts_inc : ages[w];
      end
    end
  end

endmodule

// File: sv/set_assoc_cache_tag_replacement_core.sv
// Tag and replacement engine of a set-associative cache.
// An accepted item passes the ST_LOOKUP and ST_UPDATE states; out_strobe and the result
// are registered as ST_UPDATE ends, when the core returns to ST_IDLE.
// Each item reads, looks up and writes back one set row; no new item is taken until ST_IDLE.
// On reset a clearing pass over all NUM_SETS rows zeroes the valid/age memory, busy stays high.
// The result is shown for one cycle on out_strobe; the receiver cannot stall.
// Depends on satr_pkg, satr_ram and satr_repl.
module set_assoc_cache_tag_replacement_core #(
  parameter int NUM_WAYS   = satr_pkg::DEF_NUM_WAYS,
  parameter int NUM_SETS   = satr_pkg::DEF_NUM_SETS,
  parameter int LINE_BYTES = satr_pkg::DEF_LINE_BYTES,
  parameter int ADDR_BITS  = satr_pkg::DEF_ADDR_BITS,
  parameter int WAY_W      = $clog2(NUM_WAYS),
  parameter int LINE_W     = ADDR_BITS - $clog2(LINE_BYTES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_BITS-1:0] in_byte_address,
  output logic                 out_strobe,
  output logic                 out_hit,
  output logic [WAY_W-1:0]     out_way_used,
  output logic                 out_writeback_valid,
  output logic [LINE_W-1:0]    out_writeback_line,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SETB   = $clog2(NUM_SETS);
  localparam int SET_W  = (SETB > 0) ? SETB : 1;
  localparam int TAG_W  = LINE_W - SETB;
  localparam int AGE_W  = satr_pkg::AGE_W;
  localparam int ST_W   = NUM_WAYS * (AGE_W + 1);
  localparam int TROW_W = NUM_WAYS * TAG_W;

  satr_pkg::state_t state_r, state_nxt;

  logic                 policy_r;
  logic [LINE_W-1:0]    line_r;
  logic [SET_W-1:0]     clr_idx_r;
  logic [AGE_W-1:0]     ts_r;
  logic                 hit_r;
  logic [WAY_W-1:0]     way_r;

  logic                 accept;
  logic [LINE_W-1:0]    line_in;
  logic [SET_W-1:0]     set_in;
  logic [SET_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;
  logic [AGE_W-1:0]     ts_inc;

  // Memory ports.
  logic                 st_we;
  logic [SET_W-1:0]     st_waddr;
  logic [ST_W-1:0]      st_wdata;
  logic [ST_W-1:0]      st_rdata;
  logic                 tag_we;
  logic [TROW_W-1:0]    tag_wdata;
  logic [TROW_W-1:0]    tag_rdata;
  logic [SET_W-1:0]     raddr;

  // Unpacked views of the rows.
  logic [NUM_WAYS-1:0][AGE_W:0]     st_row;
  logic [NUM_WAYS-1:0][AGE_W:0]     st_row_new;
  logic [NUM_WAYS-1:0][AGE_W-1:0]   ages;
  logic [NUM_WAYS-1:0][AGE_W-1:0]   ages_new;
  logic [NUM_WAYS-1:0]              valids;
  logic [NUM_WAYS-1:0][TAG_W-1:0]   tags;
  logic [NUM_WAYS-1:0][TAG_W-1:0]   tags_new;

  logic                 hit;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     victim;
  logic                 wb_valid;
  logic [LINE_W-1:0]    wb_line;

  // Address split.
  assign line_in = in_byte_address[ADDR_BITS-1:OFF_W];
  assign set_in  = (SETB > 0) ? SET_W'(line_in) : '0;
  assign set_r   = (SETB > 0) ? SET_W'(line_r) : '0;
  assign tag_r   = TAG_W'(line_r >> SETB);
  assign ts_inc  = ts_r + AGE_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      satr_pkg::ST_CLEAR: begin
        if (clr_idx_r == SET_W'(NUM_SETS - 1)) begin
          state_nxt = satr_pkg::ST_IDLE;
        end
      end
      satr_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = satr_pkg::ST_LOOKUP;
        end
      end
      satr_pkg::ST_LOOKUP: state_nxt = satr_pkg::ST_UPDATE;
      satr_pkg::ST_UPDATE: state_nxt = satr_pkg::ST_IDLE;
      default:             state_nxt = satr_pkg::ST_CLEAR;
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy     = 1'b1;
    st_we    = 1'b0;
    tag_we   = 1'b0;
    st_waddr = set_r;
    raddr    = set_r;
    case (state_r)
      satr_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx_r;
      end
      satr_pkg::ST_IDLE: begin
        busy  = 1'b0;
        raddr = set_in;
      end
      satr_pkg::ST_LOOKUP: begin
      end
      satr_pkg::ST_UPDATE: begin
        st_we  = 1'b1;
        tag_we = !hit_r;
      end
      default: begin
      end
    endcase
  end

  assign accept = start && !busy;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= satr_pkg::ST_CLEAR;
      clr_idx_r <= '0;
      ts_r      <= '0;
      policy_r  <= satr_pkg::POLICY_LRU;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= (state_r == satr_pkg::ST_UPDATE);
      if (state_r == satr_pkg::ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + SET_W'(1);
      end
      if (state_r == satr_pkg::ST_UPDATE && policy_r == satr_pkg::POLICY_LRU) begin
        ts_r <= ts_inc;
      end
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_r <= line_in;
    end
    if (state_r == satr_pkg::ST_LOOKUP) begin
      hit_r <= hit;
      way_r <= hit ? hit_way : victim;
    end
    if (state_r == satr_pkg::ST_UPDATE) begin
      out_hit             <= hit_r;
      out_way_used        <= way_r;
      out_writeback_valid <= wb_valid;
      out_writeback_line  <= wb_line;
    end
  end

  // Row memories: tags, and valid bits with ages.
  satr_ram #(.DEPTH(NUM_SETS), .WIDTH(TROW_W), .AW(SET_W)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  satr_ram #(.DEPTH(NUM_SETS), .WIDTH(ST_W), .AW(SET_W)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  // Row unpacking.
  assign st_row = st_rdata;
  assign tags   = tag_rdata;
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      valids[w] = st_row[w][AGE_W];
      ages[w]   = st_row[w][AGE_W-1:0];
    end
  end

  // Tag compare across the ways; the lowest matching way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valids[w] && tags[w] == tag_r) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  satr_repl #(.NUM_WAYS(NUM_WAYS), .WAY_W(WAY_W)) u_repl (
    .policy   (policy_r),
    .ages     (ages),
    .upd_way  (way_r),
    .ts_inc   (ts_inc),
    .victim   (victim),
    .ages_new (ages_new)
  );

  // New rows for the write-back of the set.
  always_comb begin
    tags_new = tags;
    tags_new[way_r] = tag_r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      st_row_new[w] = {valids[w] || (WAY_W'(w) == way_r), ages_new[w]};
    end
  end

  assign tag_wdata = tags_new;
  assign st_wdata  = (state_r == satr_pkg::ST_CLEAR) ? '0 : st_row_new;

  // Eviction report.
  assign wb_valid = !hit_r && valids[way_r];
  assign wb_line  = wb_valid ? ((LINE_W'(tags[way_r]) << SETB) | LINE_W'(set_r)) : '0;

endmodule
